[design/csu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// csu_pkg: shared definitions for the cosine similarity unit
// Transaction types, fixed field widths and width helpers used by all stages.
// ============================================================================
package csu_pkg;

    // Input elements are signed Q4.12; the result is signed Q1.14.
    localparam int FEATURE_BITS     = 16;
    localparam int SIM_W            = 16;
    localparam int SIM_FRAC         = 14;
    localparam int Q_BITS           = SIM_FRAC + 1;
    localparam int Q14_ONE          = 1 << SIM_FRAC;
    localparam int MAX_ELEMENTS_DEF = 4096;
    localparam int QUEUE_DEPTH_DEF  = 2;

    typedef struct packed {
        logic signed [FEATURE_BITS-1:0] feature_a;
        logic signed [FEATURE_BITS-1:0] feature_b;
        logic                           last_element;
    } in_item_t;

    typedef struct packed {
        logic signed [SIM_W-1:0] similarity;
        logic                    degenerate;
    } out_item_t;

    // Bits needed for a norm sum that saturates at max_elements * 2^(2*FEATURE_BITS-2).
    function automatic int norm_width(input int max_elements);
        return $clog2(max_elements + 1) + 2 * FEATURE_BITS - 2;
    endfunction

    // One queue entry carries the signed dot sum and the two norm sums.
    function automatic int entry_width(input int max_elements);
        return 3 * norm_width(max_elements) + 1;
    endfunction

endpackage

`default_nettype wire

[design/cosine_similarity_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cosine_similarity_unit: streaming cosine similarity of two feature vectors
// Accumulates dot product and squared norms of paired Q4.12 elements and
// returns dot / sqrt(norm_a * norm_b) as Q1.14, truncated toward zero.
// ============================================================================
//
//  Channel  Handshake                    Payload     Moves
//  -------  ---------------------------  ----------  ---------------------------
//  sample   sample_valid / sample_ready  in_item_t   one element pair
//  result   result_valid / result_ready  out_item_t  one cosine per vector
//
//  The front end takes one element pair per cycle while sample_ready is
//  high. A pair marked last_element is folded into the sums, and the
//  finished sums of that vector enter a short queue in the following cycle;
//  the accumulators clear at the same time. The back end forms the products
//  on the shared half-width multiplier, then runs the bit-by-bit square root
//  and divide, with a handoff through the idle and output states; when a norm
//  is zero it goes straight to the output. Reset clears all control state and
//  the accumulators. sample_ready falls only when the queue, counting a last
//  element still in flight, is full; a stalled result waits in the output
//  register while the back end starts the next vector.
//
module cosine_similarity_unit #(
    parameter int MAX_ELEMENTS = csu_pkg::MAX_ELEMENTS_DEF,
    parameter int QUEUE_DEPTH  = csu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_ready,
    input  csu_pkg::in_item_t  sample,
    output logic               result_valid,
    input  logic               result_ready,
    output csu_pkg::out_item_t result
);

    import csu_pkg::*;

    localparam int ENTRY_W = entry_width(MAX_ELEMENTS);
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    // Sums of one finished vector travel through the queue as one word:
    // signed dot sum, then the two norm sums.
    logic               push;
    logic [ENTRY_W-1:0] push_data;
    logic               pop;
    logic               head_valid;
    logic [ENTRY_W-1:0] head_data;
    logic [COUNT_W-1:0] q_count;

    csu_front #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .QUEUE_DEPTH  (QUEUE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .push         (push),
        .push_data    (push_data),
        .q_count      (q_count)
    );

    csu_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data),
        .count      (q_count)
    );

    csu_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_data    (head_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

[design/csu_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// csu_queue: short queue of finished vector sums
// Register-based FIFO between the accumulating front end and the divider.
// ============================================================================
module csu_queue #(
    parameter int WIDTH = 130,
    parameter int DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             push_data,
    input  logic                         pop,
    output logic                         head_valid,
    output logic [WIDTH-1:0]             head_data,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign count      = count_reg;

    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg < COUNT_W'(DEPTH))
        else $error("queue push while full");

    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue pop while empty");

endmodule

`default_nettype wire

[design/csu_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// csu_front: element intake and saturating accumulators
// Multiplies each element pair, accumulates dot and norm sums and hands
// the finished sums of a vector to the queue.
// ============================================================================
module csu_front #(
    parameter int MAX_ELEMENTS = csu_pkg::MAX_ELEMENTS_DEF,
    parameter int QUEUE_DEPTH  = csu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         sample_valid,
    output logic                                         sample_ready,
    input  csu_pkg::in_item_t                            sample,
    output logic                                         push,
    output logic [csu_pkg::entry_width(MAX_ELEMENTS)-1:0] push_data,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]             q_count
);

    import csu_pkg::*;

    localparam int NORM_W  = norm_width(MAX_ELEMENTS);
    localparam int DOT_W   = NORM_W + 1;
    localparam int PROD_W  = 2 * FEATURE_BITS;
    localparam int SQ_W    = 2 * FEATURE_BITS - 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [NORM_W-1:0]       LIM    = NORM_W'(MAX_ELEMENTS) << (2 * FEATURE_BITS - 2);
    localparam logic signed [DOT_W:0]   DOT_HI = (DOT_W+1)'(LIM);
    localparam logic signed [DOT_W:0]   DOT_LO = -DOT_HI;
    localparam logic [NORM_W:0]         NRM_HI = (NORM_W+1)'(LIM);

    logic                      s1_valid_reg;
    logic                      s1_last_reg;
    logic signed [PROD_W-1:0]  prod_ab_reg;
    logic [SQ_W-1:0]           prod_aa_reg;
    logic [SQ_W-1:0]           prod_bb_reg;
    logic signed [DOT_W-1:0]   dot_reg;
    logic [NORM_W-1:0]         na_reg;
    logic [NORM_W-1:0]         nb_reg;

    logic                      accept;
    logic signed [PROD_W-1:0]  mul_ab;
    logic signed [PROD_W-1:0]  mul_aa;
    logic signed [PROD_W-1:0]  mul_bb;
    logic signed [DOT_W:0]     dot_sum;
    logic [NORM_W:0]           na_sum;
    logic [NORM_W:0]           nb_sum;
    logic signed [DOT_W-1:0]   dot_next;
    logic [NORM_W-1:0]         na_next;
    logic [NORM_W-1:0]         nb_next;
    logic                      pend_last;
    logic [COUNT_W:0]          busy;

    assign accept = sample_valid && sample_ready;
    assign mul_ab = sample.feature_a * sample.feature_b;
    assign mul_aa = sample.feature_a * sample.feature_a;
    assign mul_bb = sample.feature_b * sample.feature_b;

    // Saturating sums; a single product never reaches the limit.
    always_comb
    begin
        dot_sum = (DOT_W+1)'(dot_reg) + (DOT_W+1)'(prod_ab_reg);
        na_sum  = (NORM_W+1)'(na_reg) + (NORM_W+1)'(prod_aa_reg);
        nb_sum  = (NORM_W+1)'(nb_reg) + (NORM_W+1)'(prod_bb_reg);
        if (dot_sum > DOT_HI)
        begin
            dot_next = DOT_HI[DOT_W-1:0];
        end
        else if (dot_sum < DOT_LO)
        begin
            dot_next = DOT_LO[DOT_W-1:0];
        end
        else
        begin
            dot_next = dot_sum[DOT_W-1:0];
        end
        na_next = (na_sum > NRM_HI) ? LIM : na_sum[NORM_W-1:0];
        nb_next = (nb_sum > NRM_HI) ? LIM : nb_sum[NORM_W-1:0];
    end

    // A last element in flight has a queue slot reserved for it.
    assign pend_last    = s1_valid_reg && s1_last_reg;
    assign busy         = (COUNT_W+1)'(q_count) + (COUNT_W+1)'(pend_last);
    assign sample_ready = (busy < (COUNT_W+1)'(QUEUE_DEPTH));

    assign push      = pend_last;
    assign push_data = {dot_next, na_next, nb_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            dot_reg      <= '0;
            na_reg       <= '0;
            nb_reg       <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                s1_last_reg <= sample.last_element;
            end
            if (s1_valid_reg)
            begin
                if (s1_last_reg)
                begin
                    dot_reg <= '0;
                    na_reg  <= '0;
                    nb_reg  <= '0;
                end
                else
                begin
                    dot_reg <= dot_next;
                    na_reg  <= na_next;
                    nb_reg  <= nb_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_ab_reg <= mul_ab;
            prod_aa_reg <= mul_aa[SQ_W-1:0];
            prod_bb_reg <= mul_bb[SQ_W-1:0];
        end
    end

    a_clear_after_push : assert property (@(posedge clk) disable iff (!rst_n)
        push |=> dot_reg == '0 && na_reg == '0 && nb_reg == '0)
        else $error("accumulators not cleared after vector end");

    a_norm_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        na_reg <= LIM && nb_reg <= LIM)
        else $error("norm accumulator beyond saturation limit");

endmodule

`default_nettype wire

[design/csu_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// csu_back: normalizing divider
// Forms the norm product and squared dot product with a shared half-width
// multiplier, then finds each Q1.14 cosine bit in a candidate and a test state.
// ============================================================================
module csu_back #(
    parameter int MAX_ELEMENTS = csu_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          head_valid,
    input  logic [csu_pkg::entry_width(MAX_ELEMENTS)-1:0] head_data,
    output logic                                          pop,
    output logic                                          result_valid,
    input  logic                                          result_ready,
    output csu_pkg::out_item_t                            result
);

    import csu_pkg::*;

    localparam int NORM_W    = norm_width(MAX_ELEMENTS);
    localparam int DOT_W     = NORM_W + 1;
    localparam int ENTRY_W   = entry_width(MAX_ELEMENTS);
    localparam int HALF_W    = (NORM_W + 1) / 2;
    localparam int OP_W      = 2 * HALF_W;
    localparam int PROD_W    = 4 * HALF_W;
    localparam int T_W       = PROD_W + 2 * Q_BITS + 1;
    localparam int MUL_STEPS = 8;
    localparam int STEP_W    = $clog2(MUL_STEPS + 1);
    localparam int K_W       = $clog2(Q_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_CAND,
        ST_TEST,
        ST_OUT
    } state_t;

    state_t              state_reg;
    logic [NORM_W-1:0]   na_op_reg;
    logic [NORM_W-1:0]   nb_op_reg;
    logic [NORM_W-1:0]   dm_op_reg;
    logic                neg_reg;
    logic                degen_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [OP_W-1:0]     pp_reg;
    logic [2:0]          pp_idx_reg;
    logic                pp_valid_reg;
    logic [PROD_W-1:0]   p_reg;
    logic [PROD_W-1:0]   m_reg;
    logic [T_W-1:0]      r_reg;
    logic [T_W-1:0]      a_reg;
    logic [T_W-1:0]      b_reg;
    logic [T_W-1:0]      t_reg;
    logic [Q_BITS-1:0]   q_reg;
    logic [K_W-1:0]      k_reg;
    logic                out_valid_reg;
    out_item_t           out_item_reg;

    logic signed [DOT_W-1:0] head_dot;
    logic [NORM_W-1:0]   head_na;
    logic [NORM_W-1:0]   head_nb;
    logic [DOT_W-1:0]    head_abs;
    logic [OP_W-1:0]     mul_x;
    logic [OP_W-1:0]     mul_y;
    logic [HALF_W-1:0]   mul_xh;
    logic [HALF_W-1:0]   mul_yh;
    logic [OP_W-1:0]     mul_pp;
    logic [1:0]          pp_shift;
    logic [PROD_W-1:0]   pp_aligned;
    logic [T_W:0]        diff;
    logic [Q_BITS-1:0]   q_cap;
    logic [SIM_W-1:0]    sim_mag;
    logic [SIM_W-1:0]    sim_val;
    logic                out_free;

    assign head_dot = head_data[ENTRY_W-1 -: DOT_W];
    assign head_na  = head_data[2*NORM_W-1 -: NORM_W];
    assign head_nb  = head_data[NORM_W-1:0];
    assign head_abs = head_dot[DOT_W-1] ? -head_dot : head_dot;

    assign pop      = (state_reg == ST_IDLE) && head_valid;
    assign out_free = !out_valid_reg || result_ready;

    // Partial product x_half[i] * y_half[j]; steps 0..3 form the norm product,
    // steps 4..7 the squared dot magnitude.
    always_comb
    begin
        mul_x  = step_reg[2] ? OP_W'(dm_op_reg) : OP_W'(na_op_reg);
        mul_y  = step_reg[2] ? OP_W'(dm_op_reg) : OP_W'(nb_op_reg);
        mul_xh = step_reg[0] ? mul_x[OP_W-1:HALF_W] : mul_x[HALF_W-1:0];
        mul_yh = step_reg[1] ? mul_y[OP_W-1:HALF_W] : mul_y[HALF_W-1:0];
        mul_pp = OP_W'(mul_xh) * OP_W'(mul_yh);
    end

    always_comb
    begin
        pp_shift = {1'b0, pp_idx_reg[0]} + {1'b0, pp_idx_reg[1]};
        case (pp_shift)
            2'd0:    pp_aligned = PROD_W'(pp_reg);
            2'd1:    pp_aligned = PROD_W'(pp_reg) << HALF_W;
            2'd2:    pp_aligned = PROD_W'(pp_reg) << (2 * HALF_W);
            default: pp_aligned = PROD_W'(pp_reg);
        endcase
    end

    // Candidate bit is kept when its growth of q^2 * P still fits the remainder.
    assign diff = {1'b0, r_reg} - {1'b0, t_reg};

    always_comb
    begin
        q_cap   = (q_reg > Q_BITS'(Q14_ONE)) ? Q_BITS'(Q14_ONE) : q_reg;
        sim_mag = SIM_W'(q_cap);
        sim_val = neg_reg ? -sim_mag : sim_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            na_op_reg     <= '0;
            nb_op_reg     <= '0;
            dm_op_reg     <= '0;
            neg_reg       <= 1'b0;
            degen_reg     <= 1'b0;
            step_reg      <= '0;
            pp_reg        <= '0;
            pp_idx_reg    <= '0;
            pp_valid_reg  <= 1'b0;
            p_reg         <= '0;
            m_reg         <= '0;
            r_reg         <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            t_reg         <= '0;
            q_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            // A new result may load in the same cycle the old one is taken.
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (head_valid)
                    begin
                        na_op_reg    <= head_na;
                        nb_op_reg    <= head_nb;
                        dm_op_reg    <= head_abs[NORM_W-1:0];
                        neg_reg      <= head_dot[DOT_W-1];
                        q_reg        <= '0;
                        step_reg     <= '0;
                        pp_valid_reg <= 1'b0;
                        p_reg        <= '0;
                        m_reg        <= '0;
                        if (head_na == '0 || head_nb == '0)
                        begin
                            degen_reg <= 1'b1;
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            degen_reg <= 1'b0;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    if (step_reg != STEP_W'(MUL_STEPS))
                    begin
                        pp_reg       <= mul_pp;
                        pp_idx_reg   <= step_reg[2:0];
                        pp_valid_reg <= 1'b1;
                        step_reg     <= step_reg + STEP_W'(1);
                    end
                    else
                    begin
                        pp_valid_reg <= 1'b0;
                        state_reg    <= ST_PREP;
                    end
                    if (pp_valid_reg)
                    begin
                        if (pp_idx_reg[2])
                        begin
                            m_reg <= m_reg + pp_aligned;
                        end
                        else
                        begin
                            p_reg <= p_reg + pp_aligned;
                        end
                    end
                end
                ST_PREP:
                begin
                    r_reg     <= T_W'(m_reg) << (2 * SIM_FRAC);
                    a_reg     <= T_W'(p_reg) << (2 * (Q_BITS - 1));
                    b_reg     <= '0;
                    k_reg     <= K_W'(Q_BITS - 1);
                    state_reg <= ST_CAND;
                end
                ST_CAND:
                begin
                    t_reg     <= a_reg + b_reg;
                    state_reg <= ST_TEST;
                end
                ST_TEST:
                begin
                    a_reg <= a_reg >> 2;
                    if (!diff[T_W])
                    begin
                        r_reg <= diff[T_W-1:0];
                        b_reg <= (b_reg >> 1) + a_reg;
                        q_reg <= q_reg | (Q_BITS'(1) << k_reg);
                    end
                    else
                    begin
                        b_reg <= b_reg >> 1;
                    end
                    if (k_reg == '0)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        k_reg     <= k_reg - K_W'(1);
                        state_reg <= ST_CAND;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_item_reg.similarity <= degen_reg ? '0 : sim_val;
                        out_item_reg.degenerate <= degen_reg;
                        state_reg               <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    a_products_done : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PREP |-> !pp_valid_reg)
        else $error("search started before all partial products were summed");

    a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.degenerate |-> out_item_reg.similarity == '0)
        else $error("degenerate result with nonzero similarity");

    a_sim_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_item_reg.similarity <= SIM_W'(Q14_ONE)
            && out_item_reg.similarity >= -SIM_W'(Q14_ONE))
        else $error("similarity outside unit range");

endmodule

`default_nettype wire
